FILE: hw/rtl/pwfp_pkg.sv
// ----------------------------------------------------------------------------
// Protobuf wire field parser package
// Phase encoding, result kinds, wire types, error codes and the shared
// structures passed between the parser step logic and the top level.
// ----------------------------------------------------------------------------
package pwfp_pkg;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VARVAL  = 3'd1,
        PH_FIXED   = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DISCARD = 3'd5
    } phase_t;

    localparam logic [1:0] KIND_SCALAR  = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [2:0] WIRE_VARINT      = 3'd0;
    localparam logic [2:0] WIRE_FIXED64     = 3'd1;
    localparam logic [2:0] WIRE_LEN         = 3'd2;
    localparam logic [2:0] WIRE_START_GROUP = 3'd3;
    localparam logic [2:0] WIRE_END_GROUP   = 3'd4;
    localparam logic [2:0] WIRE_FIXED32     = 3'd5;

    localparam logic [2:0] ERR_TRUNCATED   = 3'd0;
    localparam logic [2:0] ERR_VARINT_LONG = 3'd1;
    localparam logic [2:0] ERR_FIELD_ZERO  = 3'd2;
    localparam logic [2:0] ERR_FIELD_WIDE  = 3'd3;
    localparam logic [2:0] ERR_BAD_WIRE    = 3'd4;
    localparam logic [2:0] ERR_GROUP       = 3'd5;

    localparam logic [3:0] VARINT_MAX_BYTES  = 4'd10;
    localparam logic [3:0] FIXED32_BYTES     = 4'd4;
    localparam logic [3:0] FIXED64_BYTES     = 4'd8;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  group_count;
        logic [63:0] accumulator;
        logic [31:0] current_field;
        logic [2:0]  current_wire;
        logic [31:0] payload_left;
    } core_state_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] field_number;
        logic [2:0]  wire_kind;
        logic [63:0] field_value;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [2:0]  error_code;
        logic [31:0] error_offset;
    } result_t;

endpackage

FILE: hw/rtl/pwfp_in_if.sv
// ----------------------------------------------------------------------------
// Message byte channel
// Valid/ready channel carrying one byte of the encoded buffer per item.
// ----------------------------------------------------------------------------
interface pwfp_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink (input valid, input data_byte, input end_of_buffer, output ready);

endinterface

FILE: hw/rtl/pwfp_out_if.sv
// ----------------------------------------------------------------------------
// Parse result channel
// Valid/ready channel carrying one decoded field, payload byte or error.
// ----------------------------------------------------------------------------
interface pwfp_out_if;

    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] field_number;
    logic [2:0]  wire_kind;
    logic [63:0] field_value;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [2:0]  error_code;
    logic [31:0] error_offset;

    modport source (
        output valid, output result_kind, output field_number, output wire_kind,
        output field_value, output payload_byte, output payload_last,
        output error_code, output error_offset, input ready
    );
    modport sink (
        input valid, input result_kind, input field_number, input wire_kind,
        input field_value, input payload_byte, input payload_last,
        input error_code, input error_offset, output ready
    );

endinterface

FILE: hw/rtl/pwfp_step.sv
// ----------------------------------------------------------------------------
// Parser step logic
// Combinational update of the parser state for one message byte, together
// with the result item (if any) that the byte produces.
// ----------------------------------------------------------------------------
module pwfp_step
    import pwfp_pkg::*;
#(
    parameter int OFFSET_BITS = 32
)
(
    input  core_state_t            state,
    input  logic [OFFSET_BITS-1:0] byte_offset,
    input  logic [OFFSET_BITS-1:0] item_start_offset,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_buffer,
    output core_state_t            state_next,
    output logic [OFFSET_BITS-1:0] byte_offset_next,
    output logic [OFFSET_BITS-1:0] item_start_offset_next,
    output logic                   has_result,
    output result_t                result
);

    logic [OFFSET_BITS-1:0] here;
    logic [OFFSET_BITS-1:0] next_off;
    logic [OFFSET_BITS-1:0] start_var;
    logic [OFFSET_BITS-1:0] err_at;
    logic [63:0]            acc_base;
    logic [63:0]            acc_var;
    logic [63:0]            acc_fix;
    logic [5:0]             var_shift;
    logic [3:0]             gc_inc;
    logic [3:0]             fix_count;
    logic [3:0]             fix_need;
    logic [31:0]            left_dec;
    logic                   err_hit;
    logic [2:0]             err_code;

    always_comb
    begin
        here      = byte_offset;
        next_off  = byte_offset + OFFSET_BITS'(1);
        // A new varint starts when no byte of it has been taken yet.
        acc_base  = (state.group_count == 4'd0) ? 64'd0 : state.accumulator;
        start_var = (state.group_count == 4'd0) ? here : item_start_offset;
        var_shift = {2'b00, state.group_count} * 6'd7;
        acc_var   = acc_base | (64'(data_byte[6:0]) << var_shift);
        gc_inc    = state.group_count + 4'd1;
        acc_fix   = state.accumulator | (64'(data_byte) << {state.group_count[2:0], 3'b000});
        fix_count = {1'b0, state.group_count[2:0]} + 4'd1;
        fix_need  = (state.current_wire == WIRE_FIXED32) ? FIXED32_BYTES : FIXED64_BYTES;
        left_dec  = (state.payload_left != 32'd0) ? state.payload_left - 32'd1
                                                  : state.payload_left;

        state_next             = state;
        item_start_offset_next = item_start_offset;
        has_result             = 1'b0;
        result                 = '0;
        err_hit                = 1'b0;
        err_code               = ERR_TRUNCATED;
        err_at                 = item_start_offset;

        case (state.phase)
            PH_TAG, PH_VARVAL, PH_LENGTH:
            begin
                state_next.accumulator = acc_var;
                state_next.group_count = gc_inc;
                item_start_offset_next = start_var;
                if (data_byte[7])
                begin
                    if (gc_inc >= VARINT_MAX_BYTES)
                    begin
                        err_hit  = 1'b1;
                        err_code = ERR_VARINT_LONG;
                        err_at   = start_var;
                    end
                    else if (end_of_buffer)
                    begin
                        err_hit  = 1'b1;
                        err_code = ERR_TRUNCATED;
                        err_at   = next_off;
                    end
                end
                else
                begin
                    state_next.group_count = 4'd0;
                    case (state.phase)
                        PH_TAG:
                        begin
                            if (acc_var[63:3] == 61'd0)
                            begin
                                err_hit  = 1'b1;
                                err_code = ERR_FIELD_ZERO;
                                err_at   = start_var;
                            end
                            else if (acc_var[63:35] != 29'd0)
                            begin
                                err_hit  = 1'b1;
                                err_code = ERR_FIELD_WIDE;
                                err_at   = start_var;
                            end
                            else if (acc_var[2:0] > WIRE_FIXED32)
                            begin
                                err_hit  = 1'b1;
                                err_code = ERR_BAD_WIRE;
                                err_at   = start_var;
                            end
                            else if (acc_var[2:0] inside {WIRE_START_GROUP, WIRE_END_GROUP})
                            begin
                                err_hit  = 1'b1;
                                err_code = ERR_GROUP;
                                err_at   = next_off;
                            end
                            else
                            begin
                                state_next.current_field = acc_var[34:3];
                                state_next.current_wire  = acc_var[2:0];
                                state_next.accumulator   = 64'd0;
                                item_start_offset_next   = next_off;
                                case (acc_var[2:0])
                                    WIRE_VARINT: state_next.phase = PH_VARVAL;
                                    WIRE_LEN:    state_next.phase = PH_LENGTH;
                                    default:     state_next.phase = PH_FIXED;
                                endcase
                                // A tag with nothing after it is a truncated field.
                                if (end_of_buffer)
                                begin
                                    err_hit  = 1'b1;
                                    err_code = ERR_TRUNCATED;
                                    err_at   = next_off;
                                end
                            end
                        end
                        PH_LENGTH:
                        begin
                            if (acc_var[63:32] != 32'd0)
                            begin
                                err_hit  = 1'b1;
                                err_code = ERR_TRUNCATED;
                                err_at   = start_var;
                            end
                            else if (acc_var == 64'd0)
                            begin
                                state_next.phase    = PH_TAG;
                                has_result          = 1'b1;
                                result.result_kind  = KIND_HEADER;
                                result.field_number = state.current_field;
                                result.wire_kind    = state.current_wire;
                            end
                            else if (end_of_buffer)
                            begin
                                err_hit  = 1'b1;
                                err_code = ERR_TRUNCATED;
                                err_at   = start_var;
                            end
                            else
                            begin
                                state_next.payload_left = acc_var[31:0];
                                state_next.phase        = PH_PAYLOAD;
                                has_result              = 1'b1;
                                result.result_kind      = KIND_HEADER;
                                result.field_number     = state.current_field;
                                result.wire_kind        = state.current_wire;
                                result.field_value      = acc_var;
                            end
                        end
                        default:
                        begin
                            state_next.phase    = PH_TAG;
                            has_result          = 1'b1;
                            result.result_kind  = KIND_SCALAR;
                            result.field_number = state.current_field;
                            result.wire_kind    = state.current_wire;
                            result.field_value  = acc_var;
                        end
                    endcase
                end
            end
            PH_FIXED:
            begin
                state_next.accumulator = acc_fix;
                state_next.group_count = fix_count;
                if (fix_count >= fix_need)
                begin
                    state_next.group_count = 4'd0;
                    state_next.phase       = PH_TAG;
                    has_result             = 1'b1;
                    result.result_kind     = KIND_SCALAR;
                    result.field_number    = state.current_field;
                    result.wire_kind       = state.current_wire;
                    result.field_value     = acc_fix;
                end
                else if (end_of_buffer)
                begin
                    err_hit  = 1'b1;
                    err_code = ERR_TRUNCATED;
                    err_at   = item_start_offset;
                end
            end
            PH_PAYLOAD:
            begin
                state_next.payload_left = left_dec;
                if (left_dec == 32'd0)
                begin
                    state_next.phase    = PH_TAG;
                    has_result          = 1'b1;
                    result.result_kind  = KIND_PAYLOAD;
                    result.payload_byte = data_byte;
                    result.payload_last = 1'b1;
                end
                else if (end_of_buffer)
                begin
                    err_hit  = 1'b1;
                    err_code = ERR_TRUNCATED;
                    err_at   = item_start_offset;
                end
                else
                begin
                    has_result          = 1'b1;
                    result.result_kind  = KIND_PAYLOAD;
                    result.payload_byte = data_byte;
                end
            end
            default:
            begin
                // Discarding until the buffer ends.
            end
        endcase

        if (err_hit)
        begin
            has_result             = 1'b1;
            result                 = '0;
            result.result_kind     = KIND_ERROR;
            result.error_code      = err_code;
            result.error_offset    = 32'(err_at);
            state_next.phase       = PH_DISCARD;
            state_next.group_count = 4'd0;
        end

        byte_offset_next = next_off;
        // The last byte of a buffer returns the parser to the tag phase at offset 0.
        if (end_of_buffer)
        begin
            state_next.phase        = PH_TAG;
            state_next.group_count  = 4'd0;
            state_next.accumulator  = 64'd0;
            state_next.payload_left = 32'd0;
            byte_offset_next        = '0;
        end
    end

endmodule

FILE: hw/rtl/protobuf_wire_field_parser.sv
// ----------------------------------------------------------------------------
// Protobuf wire field parser
// Decodes a protobuf message, one byte per item on the msg channel, into
// fields, payload bytes and errors on the result channel.
//
// The msg channel carries a byte and an end-of-buffer flag; the flag marks
// the last byte of a message and the next byte starts a new one at offset 0.
// The result channel gives at most one item per byte: a scalar field, a
// length-delimited header, a payload byte or an error with its byte offset.
// After an error, bytes produce nothing until the end of the buffer.
// A byte accepted on the msg channel waits in the input register until the
// output register is free; then the step logic updates the state and the
// byte's result, if any, is written to the output register and offered on
// the result channel. One byte is taken every cycle while the receiver does
// not stall; the combinational step logic is what sets that rate.
// Reset empties both registers and returns the parser to the tag phase at
// offset 0. When the receiver stalls, the result is held and the input
// register holds its byte; msg.ready falls only once both are occupied.
// ----------------------------------------------------------------------------
module protobuf_wire_field_parser
    import pwfp_pkg::*;
#(
    parameter int OFFSET_BITS = 32
)
(
    input logic        clk,
    input logic        rst_n,
    pwfp_in_if.sink    msg,
    pwfp_out_if.source result
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    core_state_t            state_reg;
    core_state_t            state_next;
    logic [OFFSET_BITS-1:0] byte_offset_reg;
    logic [OFFSET_BITS-1:0] byte_offset_next;
    logic [OFFSET_BITS-1:0] item_start_reg;
    logic [OFFSET_BITS-1:0] item_start_next;
    logic                   out_valid_reg;
    result_t                out_reg;
    result_t                step_result;
    logic                   step_has_result;
    logic                   out_free;
    logic                   fire;
    logic                   msg_take;

    assign out_free  = !out_valid_reg || result.ready;
    assign fire      = in_valid_reg && out_free;
    assign msg.ready = !in_valid_reg || fire;
    assign msg_take  = msg.valid && msg.ready;

    pwfp_step #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_step (
        .state                  (state_reg),
        .byte_offset            (byte_offset_reg),
        .item_start_offset      (item_start_reg),
        .data_byte              (in_byte_reg),
        .end_of_buffer          (in_last_reg),
        .state_next             (state_next),
        .byte_offset_next       (byte_offset_next),
        .item_start_offset_next (item_start_next),
        .has_result             (step_has_result),
        .result                 (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (msg_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg_take)
        begin
            in_byte_reg <= msg.data_byte;
            in_last_reg <= msg.end_of_buffer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= PH_TAG;
            state_reg.group_count   <= 4'd0;
            state_reg.accumulator   <= 64'd0;
            state_reg.current_field <= 32'd0;
            state_reg.current_wire  <= WIRE_VARINT;
            state_reg.payload_left  <= 32'd0;
            byte_offset_reg         <= '0;
            item_start_reg          <= '0;
        end
        else if (fire)
        begin
            state_reg       <= state_next;
            byte_offset_reg <= byte_offset_next;
            item_start_reg  <= item_start_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && step_has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && step_has_result)
        begin
            out_reg <= step_result;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.result_kind  = out_reg.result_kind;
    assign result.field_number = out_reg.field_number;
    assign result.wire_kind    = out_reg.wire_kind;
    assign result.field_value  = out_reg.field_value;
    assign result.payload_byte = out_reg.payload_byte;
    assign result.payload_last = out_reg.payload_last;
    assign result.error_code   = out_reg.error_code;
    assign result.error_offset = out_reg.error_offset;

`ifndef NO_ASSERTIONS
    // The last byte of a buffer must leave the parser at offset 0 in the tag phase.
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_last_reg |=> byte_offset_reg == '0 && state_reg.phase == PH_TAG)
        else $error("parser not returned to start after end of buffer");

    // A varint never holds more than nine bytes between steps.
    a_group_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.group_count <= 4'd9)
        else $error("group count out of range");

    // An error in mid-buffer sends the parser to discard.
    a_error_discard: assert property (@(posedge clk) disable iff (!rst_n)
        fire && step_has_result && step_result.result_kind == KIND_ERROR && !in_last_reg
        |=> state_reg.phase == PH_DISCARD)
        else $error("error did not enter discard");

    // Payload phase always has bytes still due.
    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_PAYLOAD |-> state_reg.payload_left != 32'd0)
        else $error("payload phase with nothing left");
`endif

endmodule
